/* rtl/ascending_list_sorter_defines.svh */
// ----------------------------------------------------------------------------
// ascending_list_sorter_defines
// assertion macros used by the ascending_list_sorter rtl
// ----------------------------------------------------------------------------
`ifndef ASCENDING_LIST_SORTER_DEFINES_SVH
`define ASCENDING_LIST_SORTER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define ALS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sorter check failed");

// next-cycle implication, checked outside reset
`define ALS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sorter check failed");

`endif

/* rtl/als_pkg.sv */
// ----------------------------------------------------------------------------
// als_pkg
// shared constants and types of the ascending list sorter
// ----------------------------------------------------------------------------
package als_pkg;

  localparam int MAX_LEN = 32;
  localparam int DATA_W  = 32;
  localparam int CNT_W   = $clog2(MAX_LEN + 1);

  typedef struct packed {
    logic              valid;
    logic [DATA_W-1:0] value;
  } cell_t;

endpackage

/* rtl/als_cell.sv */
// ----------------------------------------------------------------------------
// als_cell
// one sorting cell: holds one element, takes a new one or its left
// neighbor's on insert, takes its right neighbor's on drain
// ----------------------------------------------------------------------------
module als_cell (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        ins_en,
  input  logic                        shift_en,
  input  logic [als_pkg::DATA_W-1:0]  x,
  input  als_pkg::cell_t              left_q,
  input  logic                        left_gt,
  input  als_pkg::cell_t              right_q,
  output als_pkg::cell_t              q,
  output logic                        gt
);

  assign gt = !q.valid || ($signed(x) < $signed(q.value));

  always_ff @(posedge clk) begin
    if (rst) begin
      q.valid <= 1'b0;
    end else if (shift_en) begin
      q <= right_q;
    end else if (ins_en && gt) begin
      if (left_gt) begin
        q <= left_q;
      end else begin
        q.valid <= 1'b1;
        q.value <= x;
      end
    end
  end

endmodule

/* rtl/ascending_list_sorter.sv */
// ----------------------------------------------------------------------------
// ascending_list_sorter
// collects a list of signed values and returns it in ascending order
// ----------------------------------------------------------------------------
// channel  ports                                  transfer when
// input    start, busy, value, last               start && !busy
// result   strobe, sorted_value, final_res,       strobe
//          dropped
//
// an element enters the row in the cycle after it is accepted: every cell
// compares it at once and the row shifts right past the insert point, so
// elements go in back to back; after the last element the row drains from
// cell 0, one result a cycle and one per stored element; busy is high during
// the drain only; synchronous reset empties the row; the receiver cannot stall
// ----------------------------------------------------------------------------
`include "ascending_list_sorter_defines.svh"

module ascending_list_sorter (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic signed [31:0]          value,
  input  logic                        last,
  output logic                        strobe,
  output logic signed [31:0]          sorted_value,
  output logic                        final_res,
  output logic                        dropped
);

  localparam logic ST_FILL  = 1'b0;
  localparam logic ST_DRAIN = 1'b1;

  logic                         state;
  logic [als_pkg::CNT_W-1:0]    count;
  logic                         overflow;
  logic                         accept;
  logic                         full;
  logic                         ins_en;
  logic                         shift_en;
  als_pkg::cell_t               q      [als_pkg::MAX_LEN];
  logic                         gt     [als_pkg::MAX_LEN];
  logic [als_pkg::MAX_LEN-1:0]  valid_vec;

  assign busy     = (state == ST_DRAIN);
  assign accept   = start && !busy;
  assign full     = (count == als_pkg::CNT_W'(als_pkg::MAX_LEN));
  assign ins_en   = accept && !full;
  assign shift_en = (state == ST_DRAIN);

  genvar i;
  generate
    for (i = 0; i < als_pkg::MAX_LEN; i++) begin : g_cell
      als_pkg::cell_t left_q;
      als_pkg::cell_t right_q;
      logic           left_gt;

      if (i == 0) begin : g_first
        assign left_q  = '0;
        assign left_gt = 1'b0;
      end else begin : g_mid
        assign left_q  = q[i-1];
        assign left_gt = gt[i-1];
      end

      if (i == als_pkg::MAX_LEN - 1) begin : g_end
        assign right_q = '0;
      end else begin : g_inner
        assign right_q = q[i+1];
      end

      als_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .ins_en   (ins_en),
        .shift_en (shift_en),
        .x        (value),
        .left_q   (left_q),
        .left_gt  (left_gt),
        .right_q  (right_q),
        .q        (q[i]),
        .gt       (gt[i])
      );

      assign valid_vec[i] = q[i].valid;
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_FILL;
      count    <= '0;
      overflow <= 1'b0;
    end else begin
      unique case (state)
        ST_FILL: begin
          if (accept) begin
            if (full) begin
              overflow <= 1'b1;
            end else begin
              count <= count + 1'b1;
            end
            if (last) begin
              state <= ST_DRAIN;
            end
          end
        end
        ST_DRAIN: begin
          if (final_res) begin
            count    <= '0;
            overflow <= 1'b0;
            state    <= ST_FILL;
          end else begin
            count <= count - 1'b1;
          end
        end
        default: begin
          state <= ST_FILL;
        end
      endcase
    end
  end

  assign strobe       = (state == ST_DRAIN);
  assign sorted_value = $signed(q[0].value);
  assign final_res    = (count == als_pkg::CNT_W'(1));
  assign dropped      = overflow;

  `ALS_ASSERT_NOW(a_count_matches_cells, 1'b1, $countones(valid_vec) == count)
  `ALS_ASSERT_NEXT(a_drain_continues, strobe && !final_res, strobe)
  `ALS_ASSERT_NEXT(a_drain_ends, strobe && final_res, !busy && (count == '0))
  `ALS_ASSERT_NEXT(a_last_starts_drain, accept && last, busy && !overflow == !$past(overflow || full))

endmodule
